// File: hdl/eoc_pkg.sv
// Shared types, constants and microcode table for the epoch-to-calendar converter.
package eoc_pkg;

    localparam int unsigned REM_W  = 33;
    localparam int unsigned PC_W   = 3;
    localparam int unsigned OFS_W  = 17;

    localparam logic [OFS_W-1:0] OFFSET_RESET = 17'd32400;
    localparam logic [11:0]      EPOCH_YEAR   = 12'd1970;

    localparam logic [REM_W-1:0] SECS_DAY    = 33'd86400;
    localparam logic [REM_W-1:0] SECS_HOUR   = 33'd3600;
    localparam logic [REM_W-1:0] SECS_MIN    = 33'd60;
    localparam logic [REM_W-1:0] SECS_LEAP   = 33'd31622400;
    localparam logic [REM_W-1:0] SECS_COMMON = 33'd31536000;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_YEAR,
        OP_MONTH,
        OP_DAY,
        OP_HOUR,
        OP_MIN
    } t_opsel;

    // one control word per step
    typedef struct packed {
        logic            load;
        logic            done;
        t_opsel          op;
        logic [PC_W-1:0] next;
    } t_uword;

    typedef struct packed {
        logic   accept;
        logic   take;
        logic   done;
        t_opsel op;
    } t_ctl;

    localparam logic [PC_W-1:0] ST_IDLE  = 3'd0;
    localparam logic [PC_W-1:0] ST_YEAR  = 3'd1;
    localparam logic [PC_W-1:0] ST_MONTH = 3'd2;
    localparam logic [PC_W-1:0] ST_DAY   = 3'd3;
    localparam logic [PC_W-1:0] ST_HOUR  = 3'd4;
    localparam logic [PC_W-1:0] ST_MIN   = 3'd5;
    localparam logic [PC_W-1:0] ST_DONE  = 3'd6;

    function automatic t_uword f_urom(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{load: 1'b0, done: 1'b0, op: OP_NONE, next: ST_IDLE};
        unique case (pc)
            ST_IDLE:  begin w.load = 1'b1; w.next = ST_YEAR; end
            ST_YEAR:  begin w.op = OP_YEAR;  w.next = ST_MONTH; end
            ST_MONTH: begin w.op = OP_MONTH; w.next = ST_DAY; end
            ST_DAY:   begin w.op = OP_DAY;   w.next = ST_HOUR; end
            ST_HOUR:  begin w.op = OP_HOUR;  w.next = ST_MIN; end
            ST_MIN:   begin w.op = OP_MIN;   w.next = ST_DONE; end
            ST_DONE:  begin w.done = 1'b1;   w.next = ST_IDLE; end
            default:  begin w.next = ST_IDLE; end
        endcase
        return w;
    endfunction

    function automatic logic [REM_W-1:0] f_month_secs(input logic [3:0] month,
                                                      input logic leap);
        logic [REM_W-1:0] s;
        case (month)
            4'd2:                      s = leap ? 33'd2505600 : 33'd2419200;
            4'd4, 4'd6, 4'd9, 4'd11:   s = 33'd2592000;
            default:                   s = 33'd2678400;
        endcase
        return s;
    endfunction

endpackage

// File: hdl/epoch_seconds_to_calendar.sv
// Top level: zone offset register, microcode sequencer and datapath.
//
// Converts a 32-bit count of seconds since 1970-01-01 00:00 UTC, plus the
// signed zone offset register, into local year, month, day, hour, minute
// and second. A negative adjusted time yields the epoch with o_clamped set.
// Input: a word is taken at a clock edge with start high and busy low.
// Config: i_cfg_we writes i_cfg_wdata into the zone offset; write only
// while busy is low and no result is pending.
// Output: o_valid is high for one cycle with the result word; the
// receiver cannot stall, so the word must be taken in that cycle.
// Timing: the sequencer walks a shared 33-bit subtract/compare unit one
// step per cycle: one step per whole year, month, day, hour and minute,
// plus one exit step per field and a final step; busy drops as o_valid rises.
// A new word can be started in the cycle o_valid is high.
// Reset: the sequencer returns to idle, o_valid drops and the zone offset
// returns to +32400 seconds.
module epoch_seconds_to_calendar (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_epoch_seconds,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_wdata,
    output logic        o_valid,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second,
    output logic        o_clamped
);

    logic [eoc_pkg::OFS_W-1:0] r_offset;
    eoc_pkg::t_ctl             ctl;
    logic                      cond;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= eoc_pkg::OFFSET_RESET;
        end else if (i_cfg_we) begin
            r_offset <= i_cfg_wdata;
        end
    end

    eoc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cond  (cond),
        .busy    (busy),
        .o_ctl   (ctl)
    );

    eoc_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .i_epoch_seconds (i_epoch_seconds),
        .i_offset        (r_offset),
        .o_cond          (cond),
        .o_valid         (o_valid),
        .o_year          (o_year),
        .o_month         (o_month),
        .o_day           (o_day),
        .o_hour          (o_hour),
        .o_minute        (o_minute),
        .o_second        (o_second),
        .o_clamped       (o_clamped)
    );

endmodule

// File: hdl/eoc_seq.sv
// Microcode sequencer: step counter, control word lookup and jump logic.
module eoc_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  logic           i_cond,
    output logic           busy,
    output eoc_pkg::t_ctl  o_ctl
);

    logic [eoc_pkg::PC_W-1:0] r_pc;
    logic [eoc_pkg::PC_W-1:0] n_pc;
    eoc_pkg::t_uword          uw;
    logic                     take;

    always_comb begin
        uw   = eoc_pkg::f_urom(r_pc);
        take = (uw.op != eoc_pkg::OP_NONE) && i_cond;
        if (uw.load) begin
            n_pc = start ? uw.next : r_pc;
        end else if (take) begin
            n_pc = r_pc;
        end else begin
            n_pc = uw.next;
        end
        o_ctl.accept = uw.load && start;
        o_ctl.take   = take;
        o_ctl.done   = uw.done;
        o_ctl.op     = uw.op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= eoc_pkg::ST_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign busy = (r_pc != eoc_pkg::ST_IDLE);

endmodule

// File: hdl/eoc_dpath.sv
// Datapath: remainder register, shared subtract/compare unit and field counters.
module eoc_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  eoc_pkg::t_ctl                i_ctl,
    input  logic [31:0]                  i_epoch_seconds,
    input  logic [eoc_pkg::OFS_W-1:0]    i_offset,
    output logic                         o_cond,
    output logic                         o_valid,
    output logic [11:0]                  o_year,
    output logic [3:0]                   o_month,
    output logic [4:0]                   o_day,
    output logic [4:0]                   o_hour,
    output logic [5:0]                   o_minute,
    output logic [5:0]                   o_second,
    output logic                         o_clamped
);

    logic [eoc_pkg::REM_W-1:0] r_rem;
    logic [11:0]               r_year;
    logic [1:0]                r_m4;
    logic [6:0]                r_m100;
    logic [8:0]                r_m400;
    logic [3:0]                r_month;
    logic [4:0]                r_day;
    logic [4:0]                r_hour;
    logic [5:0]                r_minute;
    logic                      r_clamped;

    logic                      leap;
    logic [eoc_pkg::REM_W-1:0] operand;
    logic [eoc_pkg::REM_W:0]   diff;
    logic [33:0]               sum;

    always_comb begin
        leap = ((r_m4 == 2'd0) && (r_m100 != 7'd0)) || (r_m400 == 9'd0);
        case (i_ctl.op)
            eoc_pkg::OP_YEAR:  operand = leap ? eoc_pkg::SECS_LEAP : eoc_pkg::SECS_COMMON;
            eoc_pkg::OP_MONTH: operand = eoc_pkg::f_month_secs(r_month, leap);
            eoc_pkg::OP_DAY:   operand = eoc_pkg::SECS_DAY;
            eoc_pkg::OP_HOUR:  operand = eoc_pkg::SECS_HOUR;
            eoc_pkg::OP_MIN:   operand = eoc_pkg::SECS_MIN;
            default:           operand = '0;
        endcase
        diff   = {1'b0, r_rem} - {1'b0, operand};
        o_cond = !diff[eoc_pkg::REM_W]
                 && !((i_ctl.op == eoc_pkg::OP_MONTH) && (r_month == 4'd12));
        sum    = {2'b00, i_epoch_seconds}
                 + {{(34 - eoc_pkg::OFS_W){i_offset[eoc_pkg::OFS_W-1]}}, i_offset};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_rem     <= sum[33] ? '0 : sum[eoc_pkg::REM_W-1:0];
            r_clamped <= sum[33];
            r_year    <= eoc_pkg::EPOCH_YEAR;
            r_m4      <= 2'd2;
            r_m100    <= 7'd70;
            r_m400    <= 9'd370;
            r_month   <= 4'd1;
            r_day     <= 5'd1;
            r_hour    <= 5'd0;
            r_minute  <= 6'd0;
        end else if (i_ctl.take) begin
            r_rem <= diff[eoc_pkg::REM_W-1:0];
            case (i_ctl.op)
                eoc_pkg::OP_YEAR: begin
                    r_year <= r_year + 12'd1;
                    r_m4   <= r_m4 + 2'd1;
                    r_m100 <= (r_m100 == 7'd99) ? 7'd0 : r_m100 + 7'd1;
                    r_m400 <= (r_m400 == 9'd399) ? 9'd0 : r_m400 + 9'd1;
                end
                eoc_pkg::OP_MONTH: r_month  <= r_month + 4'd1;
                eoc_pkg::OP_DAY:   r_day    <= r_day + 5'd1;
                eoc_pkg::OP_HOUR:  r_hour   <= r_hour + 5'd1;
                eoc_pkg::OP_MIN:   r_minute <= r_minute + 6'd1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.done) begin
            o_year    <= r_year;
            o_month   <= r_month;
            o_day     <= r_day;
            o_hour    <= r_hour;
            o_minute  <= r_minute;
            o_second  <= r_rem[5:0];
            o_clamped <= r_clamped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_ctl.done;
        end
    end

endmodule
